FILE: hw/rtl/msba_pkg.sv
// Shared constants, register indexes and control/status types of the beam averager.
package msba_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int MAX_BEAMS_DEF = 1024;
    localparam int MAX_SCANS_DEF = 64;

    // Fixed field widths
    localparam int BEAM_W      = 10;
    localparam int RANGE_W     = 16;
    localparam int SCANS_CFG_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Per-beam accumulator widths (sum wraps at 32 bits, count at 16 bits)
    localparam int SUM_W = 32;
    localparam int CNT_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCANS     = 2'd2;

    // Register reset values
    localparam logic [RANGE_W-1:0]     RANGE_MIN_RST = 16'd100;
    localparam logic [RANGE_W-1:0]     RANGE_MAX_RST = 16'd4000;
    localparam logic [SCANS_CFG_W-1:0] SCANS_RST     = 7'd10;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // latch the input word and launch the store read
        logic clr;        // write zero at the clearing address and advance
        logic update;     // write back the updated sum and count
        logic div_start;  // launch the divider on the updated sum and count
        logic load_out;   // load the output register
        logic scan_adv;   // apply scan bookkeeping of the held word
    } msba_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic hit;        // offered beam lies below the current beam limit
        logic last_scan;  // held word belongs to the last scan of the run
        logic scan_last;  // held word carries scan_end
        logic clr_last;   // clearing address is at the final entry
        logic div_busy;   // divider still iterating
        logic out_free;   // output register can take a word this cycle
    } msba_sts_t;

endpackage

FILE: hw/rtl/msba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msba_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/msba_div.sv
// Restoring divider, one quotient bit per cycle.
module msba_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [msba_pkg::SUM_W-1:0] dividend,
    input  logic [msba_pkg::CNT_W-1:0] divisor,
    output logic                       busy,
    output logic [msba_pkg::SUM_W-1:0] quotient
);

    localparam int SUM_W  = msba_pkg::SUM_W;
    localparam int CNT_W  = msba_pkg::CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[SUM_W-1]};
        diff   = rem_sh - {1'b0, dsr_reg};
        ge     = (rem_sh >= {1'b0, dsr_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            rem_next  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            busy_next = (step_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/msba_dp.sv
// Datapath: configuration, per-beam store, scan bookkeeping, divider and output register.
module msba_dp #(
    parameter int MAX_BEAMS = msba_pkg::MAX_BEAMS_DEF,
    parameter int MAX_SCANS = msba_pkg::MAX_SCANS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msba_pkg::msba_cmd_t             cmd,
    output msba_pkg::msba_sts_t             sts,
    input  logic [msba_pkg::BEAM_W-1:0]     beam_index,
    input  logic [msba_pkg::RANGE_W-1:0]    range_mm,
    input  logic                            reading_finite,
    input  logic                            scan_end,
    input  logic                            cfg_wr_en,
    input  logic [msba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [msba_pkg::BEAM_W-1:0]     out_beam,
    output logic [msba_pkg::RANGE_W-1:0]    average_mm,
    output logic                            average_valid,
    output logic                            out_last
);

    localparam int BEAM_W  = msba_pkg::BEAM_W;
    localparam int RANGE_W = msba_pkg::RANGE_W;
    localparam int SCFG_W  = msba_pkg::SCANS_CFG_W;
    localparam int SUM_W   = msba_pkg::SUM_W;
    localparam int CNT_W   = msba_pkg::CNT_W;
    localparam int MEM_W   = SUM_W + CNT_W;
    localparam int ADDR_W  = $clog2(MAX_BEAMS);
    localparam int LEN_W   = $clog2(MAX_BEAMS + 1);
    localparam int SCAN_W  = $clog2(MAX_SCANS);
    localparam int RUN_W   = ((SCAN_W > SCFG_W) ? SCAN_W : SCFG_W) + 1;
    localparam int CMP_W   = ((LEN_W > BEAM_W) ? LEN_W : BEAM_W) + 1;

    // Configuration registers
    logic [RANGE_W-1:0] range_min_reg;
    logic [RANGE_W-1:0] range_max_reg;
    logic [SCFG_W-1:0]  scans_reg;

    // Run bookkeeping
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [LEN_W-1:0]  first_len_reg, first_len_next;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Held input word
    logic [BEAM_W-1:0]  beam_reg;
    logic [RANGE_W-1:0] range_reg;
    logic               ok_reg;
    logic               end_reg;
    logic               last_scan_reg;
    logic               avg_valid_reg;

    // Output register
    logic               out_valid_reg;
    logic [BEAM_W-1:0]  out_beam_reg;
    logic [RANGE_W-1:0] average_reg;
    logic               average_valid_reg;
    logic               out_last_reg;

    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  beam_p1;
    logic [CMP_W-1:0]  len_capped;
    logic [RUN_W-1:0]  runs;
    logic              last_scan_now;
    logic              ok_now;
    logic [MEM_W-1:0]  rdata;
    logic [SUM_W-1:0]  sum_new;
    logic [CNT_W-1:0]  count_new;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [SUM_W-1:0]  quotient;
    logic              div_busy;

    always_comb
    begin
        limit = (scan_reg == '0) ? CMP_W'(MAX_BEAMS) : CMP_W'(first_len_reg);
        if (scans_reg == '0)
        begin
            runs = RUN_W'(1);
        end
        else if (RUN_W'(scans_reg) > RUN_W'(MAX_SCANS))
        begin
            runs = RUN_W'(MAX_SCANS);
        end
        else
        begin
            runs = RUN_W'(scans_reg);
        end
        last_scan_now = (RUN_W'(scan_reg) + RUN_W'(1)) >= runs;
        ok_now = reading_finite && (range_mm >= range_min_reg) && (range_mm <= range_max_reg);

        beam_p1    = CMP_W'(beam_reg) + CMP_W'(1);
        len_capped = (beam_p1 > CMP_W'(MAX_BEAMS)) ? CMP_W'(MAX_BEAMS) : beam_p1;

        sum_new   = rdata[MEM_W-1:CNT_W] + (ok_reg ? SUM_W'(range_reg) : '0);
        count_new = rdata[CNT_W-1:0] + (ok_reg ? CNT_W'(1) : '0);

        scan_next      = scan_reg;
        first_len_next = first_len_reg;
        if (cmd.scan_adv && end_reg)
        begin
            if (last_scan_reg)
            begin
                scan_next      = '0;
                first_len_next = '0;
            end
            else
            begin
                scan_next = scan_reg + SCAN_W'(1);
                if (scan_reg == '0)
                begin
                    first_len_next = LEN_W'(len_capped);
                end
            end
        end

        mem_we    = cmd.clr || (cmd.update && ok_reg);
        mem_waddr = cmd.clr ? clr_addr_reg : ADDR_W'(beam_reg);
        mem_wdata = cmd.clr ? '0 : {sum_new, count_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= msba_pkg::RANGE_MIN_RST;
            range_max_reg <= msba_pkg::RANGE_MAX_RST;
            scans_reg     <= msba_pkg::SCANS_RST;
            scan_reg      <= '0;
            first_len_reg <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    msba_pkg::REG_RANGE_MIN: range_min_reg <= cfg_wdata;
                    msba_pkg::REG_RANGE_MAX: range_max_reg <= cfg_wdata;
                    msba_pkg::REG_SCANS:     scans_reg     <= cfg_wdata[SCFG_W-1:0];
                    default:                 ;
                endcase
            end
            scan_reg      <= scan_next;
            first_len_reg <= first_len_next;
            if (cmd.clr)
            begin
                clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            beam_reg      <= beam_index;
            range_reg     <= range_mm;
            ok_reg        <= ok_now;
            end_reg       <= scan_end;
            last_scan_reg <= last_scan_now;
        end
        if (cmd.update)
        begin
            avg_valid_reg <= (count_new != '0);
        end
        if (cmd.load_out)
        begin
            out_beam_reg      <= beam_reg;
            average_reg       <= avg_valid_reg ? quotient[RANGE_W-1:0] : '0;
            average_valid_reg <= avg_valid_reg;
            out_last_reg      <= end_reg;
        end
    end

    msba_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_BEAMS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.take),
        .raddr (ADDR_W'(beam_index)),
        .rdata (rdata)
    );

    msba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_new),
        .divisor  (count_new),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        sts.hit       = (CMP_W'(beam_index) < limit);
        sts.last_scan = last_scan_reg;
        sts.scan_last = end_reg;
        sts.clr_last  = (clr_addr_reg == ADDR_W'(MAX_BEAMS - 1));
        sts.div_busy  = div_busy;
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign out_beam      = out_beam_reg;
    assign average_mm    = average_reg;
    assign average_valid = average_valid_reg;
    assign out_last      = out_last_reg;

    // A result never leaves with a mean while flagged invalid
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !average_valid) |-> (average_mm == '0))
        else $error("invalid average carries a non-zero value");

    // Clearing and the divider never overlap
    a_clr_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !div_busy)
        else $error("clearing pass while divider busy");

    // Scan counter stays inside the run limit
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        RUN_W'(scan_reg) < RUN_W'(MAX_SCANS))
        else $error("scan counter out of range");

endmodule

FILE: hw/rtl/msba_ctrl.sv
// Controller state machine sequencing clear, update, divide, emit and scan steps.
module msba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msba_pkg::msba_sts_t sts,
    output msba_pkg::msba_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_DIV    = 6'b001000,
        S_EMIT   = 6'b010000,
        S_SCAN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = sts.hit ? S_UPDATE : S_SCAN;
                end
            end
            S_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.div_start = sts.last_scan;
                state_next    = sts.last_scan ? S_DIV : S_SCAN;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_adv = 1'b1;
                state_next   = (sts.scan_last && sts.last_scan) ? S_CLEAR : S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output loaded while occupied");

    a_div_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> sts.last_scan)
        else $error("divide launched outside last scan");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_adv && sts.scan_last && sts.last_scan) |=> (state_reg == S_CLEAR))
        else $error("run end did not start clearing pass");

    a_take_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (!sts.div_busy && !cmd.clr))
        else $error("word taken while busy");

endmodule

FILE: hw/rtl/multi_scan_beam_averager_core.sv
// Top level of the multi-scan per-beam range averager.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_stall  beam_index, range_mm, reading_finite, scan_end
//  output    out        out_valid/out_stall  out_beam, average_mm, average_valid, out_last
//  config    in         cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
//  A word outside the last scan passes through accept, update and scan step; one past
//  the beam limit goes from accept straight to the scan step. A word in the last scan
//  passes through accept, update, the divide state (quotient steps, then the done check),
//  emit and scan step. After reset, and after the scan_end word of every run's last scan,
//  a clearing pass writes each of the MAX_BEAMS store entries once with in_stall high.
//  A finished result sits in the output register, so out_stall only holds the block
//  once a second result is ready to be loaded behind it.
module multi_scan_beam_averager_core #(
    parameter int MAX_BEAMS = msba_pkg::MAX_BEAMS_DEF,
    parameter int MAX_SCANS = msba_pkg::MAX_SCANS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input word channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [msba_pkg::BEAM_W-1:0]     beam_index,
    input  logic [msba_pkg::RANGE_W-1:0]    range_mm,
    input  logic                            reading_finite,
    input  logic                            scan_end,
    // result word channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [msba_pkg::BEAM_W-1:0]     out_beam,
    output logic [msba_pkg::RANGE_W-1:0]    average_mm,
    output logic                            average_valid,
    output logic                            out_last,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [msba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Commands and status between the sequencer and the datapath
    msba_pkg::msba_cmd_t cmd;
    msba_pkg::msba_sts_t sts;

    // Sequencer: owns the handshake on the input side and steps each word through
    // store read, read-modify-write, optional divide and the output load.
    msba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: range window check, per-beam sum and count store, scan counting,
    // beam limit from the first scan, divider and output register.
    msba_dp #(
        .MAX_BEAMS (MAX_BEAMS),
        .MAX_SCANS (MAX_SCANS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .beam_index     (beam_index),
        .range_mm       (range_mm),
        .reading_finite (reading_finite),
        .scan_end       (scan_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_beam       (out_beam),
        .average_mm     (average_mm),
        .average_valid  (average_valid),
        .out_last       (out_last)
    );

endmodule
